>>> design/uort_pkg.sv
// shared constants, request and status codes, and the controller/datapath
// command and status structs for the usage ordered record table
// no dependencies
package uort_pkg;

  localparam int MAX_ENTRIES_DEF  = 16;
  localparam int RECORD_WIDTH_DEF = 32;

  // field widths of one request and one response
  localparam int REQ_W    = 3;
  localparam int IDX_W    = 4;
  localparam int WORD_W   = 32;
  localparam int USAGE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int TDATA_W  = 72;

  localparam logic [REQ_W-1:0] REQ_ADD    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_EDIT   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_BUMP   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;

  // read address select
  localparam logic [1:0] RA_IDX      = 2'd0;
  localparam logic [1:0] RA_PTR_NEXT = 2'd1;
  localparam logic [1:0] RA_I        = 2'd2;
  localparam logic [1:0] RA_J        = 2'd3;

  // write address select
  localparam logic [2:0] WA_COUNT = 3'd0;
  localparam logic [2:0] WA_IDX   = 3'd1;
  localparam logic [2:0] WA_PTR   = 3'd2;
  localparam logic [2:0] WA_I     = 3'd3;
  localparam logic [2:0] WA_J     = 3'd4;

  // write data select
  localparam logic [2:0] WD_ADD   = 3'd0;
  localparam logic [2:0] WD_EDIT  = 3'd1;
  localparam logic [2:0] WD_RDATA = 3'd2;
  localparam logic [2:0] WD_BUMP  = 3'd3;
  localparam logic [2:0] WD_CUR   = 3'd4;

  // entry count update
  localparam logic [1:0] CNT_HOLD = 2'd0;
  localparam logic [1:0] CNT_INC  = 2'd1;
  localparam logic [1:0] CNT_DEC  = 2'd2;
  localparam logic [1:0] CNT_CLR  = 2'd3;

  typedef struct packed {
    logic                load_req;
    logic                set_status;
    logic [STATUS_W-1:0] status;
    logic                rd_en;
    logic [1:0]          rd_sel;
    logic                wr_en;
    logic [2:0]          wr_sel;
    logic [2:0]          wd_sel;
    logic [1:0]          count_op;
    logic                ptr_load;
    logic                ptr_inc;
    logic                i_clr;
    logic                i_inc;
    logic                j_from_i;
    logic                j_inc;
    logic                cur_load;
    logic                rd_capture;
    logic                out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             idx_ok;
    logic             full;
    logic             few;
    logic             rm_more;
    logic             swap_need;
    logic             j_more;
    logic             i_more;
    logic             out_free;
  } dp_stat_t;

endpackage

>>> design/uort_dp.sv
// datapath: request holding registers, entry memory, loop pointers,
// held sort entry and the response register
// depends on uort_pkg
module uort_dp #(
  parameter int MAX_ENTRIES  = uort_pkg::MAX_ENTRIES_DEF,
  parameter int RECORD_WIDTH = uort_pkg::RECORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [uort_pkg::TDATA_W-1:0]  s_tdata,
  input  uort_pkg::dp_cmd_t             cmd,
  output uort_pkg::dp_stat_t            stat,
  input  logic                          m_tready,
  output logic                          m_tvalid,
  output logic [uort_pkg::TDATA_W-1:0]  m_tdata
);
  import uort_pkg::*;

  localparam int AW   = $clog2(MAX_ENTRIES);
  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;
  localparam int EW   = RECORD_WIDTH + USAGE_W;

  localparam int IDX_LSB   = REQ_W;
  localparam int WORD_LSB  = IDX_LSB + IDX_W;
  localparam int USAGE_LSB = WORD_LSB + WORD_W;

  logic [REQ_W-1:0]        req;
  logic [IDX_W-1:0]        idx;
  logic [RECORD_WIDTH-1:0] word;
  logic [USAGE_W-1:0]      nusage;
  logic [CW-1:0]           count;
  logic [AW-1:0]           ptr;
  logic [AW-1:0]           ii;
  logic [AW-1:0]           jj;
  logic [EW-1:0]           cur;
  logic [EW-1:0]           rdata;
  logic [EW-1:0]           mem [MAX_ENTRIES];
  logic [STATUS_W-1:0]     status_q;
  logic [WORD_W-1:0]       rd_rec;
  logic [USAGE_W-1:0]      rd_use;

  logic                    out_valid;
  logic [STATUS_W-1:0]     out_status;
  logic [COUNT_W-1:0]      out_count;
  logic [WORD_W-1:0]       out_rec;
  logic [USAGE_W-1:0]      out_use;

  logic [AW-1:0]           rd_addr;
  logic [AW-1:0]           wr_addr;
  logic [EW-1:0]           wr_data;

  always_comb begin
    stat.req       = req;
    stat.idx_ok    = CMPW'(idx) < CMPW'(count);
    stat.full      = count == CW'(MAX_ENTRIES);
    stat.few       = count < CW'(2);
    stat.rm_more   = (CW'(ptr) + CW'(1)) < count;
    stat.j_more    = (CW'(jj) + CW'(1)) < count;
    stat.i_more    = (CW'(ii) + CW'(2)) < count;
    stat.swap_need = rdata[USAGE_W-1:0] > cur[USAGE_W-1:0];
    stat.out_free  = !out_valid || m_tready;
  end

  always_comb begin
    case (cmd.rd_sel)
      RA_IDX:      rd_addr = AW'(idx);
      RA_PTR_NEXT: rd_addr = ptr + AW'(1);
      RA_I:        rd_addr = ii;
      RA_J:        rd_addr = jj;
      default:     rd_addr = ii;
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      WA_COUNT: wr_addr = AW'(count);
      WA_IDX:   wr_addr = AW'(idx);
      WA_PTR:   wr_addr = ptr;
      WA_I:     wr_addr = ii;
      WA_J:     wr_addr = jj;
      default:  wr_addr = ii;
    endcase
  end

  always_comb begin
    case (cmd.wd_sel)
      WD_ADD:   wr_data = {word, USAGE_W'(0)};
      WD_EDIT:  wr_data = {word, nusage};
      WD_RDATA: wr_data = rdata;
      WD_BUMP:  wr_data = {rdata[EW-1:USAGE_W], rdata[USAGE_W-1:0] + USAGE_W'(1)};
      WD_CUR:   wr_data = cur;
      default:  wr_data = cur;
    endcase
  end

  // entry memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req    <= s_tdata[REQ_W-1:0];
      idx    <= s_tdata[IDX_LSB +: IDX_W];
      word   <= RECORD_WIDTH'(s_tdata[WORD_LSB +: WORD_W]);
      nusage <= s_tdata[USAGE_LSB +: USAGE_W];
    end
    if (cmd.ptr_load) begin
      ptr <= AW'(idx);
    end else if (cmd.ptr_inc) begin
      ptr <= ptr + AW'(1);
    end
    if (cmd.i_clr) begin
      ii <= '0;
    end else if (cmd.i_inc) begin
      ii <= ii + AW'(1);
    end
    if (cmd.j_from_i) begin
      jj <= ii + AW'(1);
    end else if (cmd.j_inc) begin
      jj <= jj + AW'(1);
    end
    // held entry i of the sort; a swap writes the old value to j
    if (cmd.cur_load) begin
      cur <= rdata;
    end
    if (cmd.load_req) begin
      status_q <= ST_OK;
    end else if (cmd.set_status) begin
      status_q <= cmd.status;
    end
    if (cmd.load_req) begin
      rd_rec <= '0;
      rd_use <= '0;
    end else if (cmd.rd_capture) begin
      rd_rec <= WORD_W'(rdata[EW-1:USAGE_W]);
      rd_use <= rdata[USAGE_W-1:0];
    end
    if (cmd.out_load) begin
      out_status <= status_q;
      out_count  <= COUNT_W'(count);
      out_rec    <= rd_rec;
      out_use    <= rd_use;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      case (cmd.count_op)
        CNT_INC: count <= count + CW'(1);
        CNT_DEC: count <= count - CW'(1);
        CNT_CLR: count <= '0;
        default: count <= count;
      endcase
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = TDATA_W'({out_use, out_rec, out_count, out_status});

endmodule

>>> design/uort_ctrl.sv
// controller: sequences one request at a time through the datapath
// (decode, remove shift, bump and exchange sort, read, response)
// depends on uort_pkg
module uort_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  uort_pkg::dp_stat_t stat,
  output uort_pkg::dp_cmd_t  cmd
);
  import uort_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_EXEC     = 4'd1;
  localparam logic [3:0] S_RM       = 4'd2;
  localparam logic [3:0] S_RM_WR    = 4'd3;
  localparam logic [3:0] S_BUMP_WR  = 4'd4;
  localparam logic [3:0] S_SORT_LD  = 4'd5;
  localparam logic [3:0] S_SORT_CUR = 4'd6;
  localparam logic [3:0] S_SORT_RD  = 4'd7;
  localparam logic [3:0] S_SORT_CMP = 4'd8;
  localparam logic [3:0] S_SORT_WB  = 4'd9;
  localparam logic [3:0] S_READ_CAP = 4'd10;
  localparam logic [3:0] S_RESP     = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_req = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_RESP;
        case (stat.req)
          REQ_ADD: begin
            if (stat.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
            end else begin
              cmd.wr_en    = 1'b1;
              cmd.wr_sel   = WA_COUNT;
              cmd.wd_sel   = WD_ADD;
              cmd.count_op = CNT_INC;
            end
          end
          REQ_EDIT: begin
            if (!stat.idx_ok) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_BAD_INDEX;
            end else begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = WA_IDX;
              cmd.wd_sel = WD_EDIT;
            end
          end
          REQ_REMOVE: begin
            if (!stat.idx_ok) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_BAD_INDEX;
            end else begin
              cmd.ptr_load = 1'b1;
              state_next   = S_RM;
            end
          end
          REQ_BUMP: begin
            if (!stat.idx_ok) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_BAD_INDEX;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RA_IDX;
              state_next = S_BUMP_WR;
            end
          end
          REQ_CLEAR: begin
            cmd.count_op = CNT_CLR;
          end
          REQ_READ: begin
            if (!stat.idx_ok) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_BAD_INDEX;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RA_IDX;
              state_next = S_READ_CAP;
            end
          end
          default: begin
            state_next = S_RESP;
          end
        endcase
      end
      // shift later entries down one place
      S_RM: begin
        if (stat.rm_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_PTR_NEXT;
          state_next = S_RM_WR;
        end else begin
          cmd.count_op = CNT_DEC;
          state_next   = S_RESP;
        end
      end
      S_RM_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WA_PTR;
        cmd.wd_sel  = WD_RDATA;
        cmd.ptr_inc = 1'b1;
        state_next  = S_RM;
      end
      S_BUMP_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WA_IDX;
        cmd.wd_sel = WD_BUMP;
        if (stat.few) begin
          state_next = S_RESP;
        end else begin
          cmd.i_clr  = 1'b1;
          state_next = S_SORT_LD;
        end
      end
      S_SORT_LD: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = RA_I;
        cmd.j_from_i = 1'b1;
        state_next   = S_SORT_CUR;
      end
      S_SORT_CUR: begin
        cmd.cur_load = 1'b1;
        state_next   = S_SORT_RD;
      end
      S_SORT_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_J;
        state_next = S_SORT_CMP;
      end
      S_SORT_CMP: begin
        if (stat.swap_need) begin
          cmd.wr_en    = 1'b1;
          cmd.wr_sel   = WA_J;
          cmd.wd_sel   = WD_CUR;
          cmd.cur_load = 1'b1;
        end
        if (stat.j_more) begin
          cmd.j_inc  = 1'b1;
          state_next = S_SORT_RD;
        end else begin
          state_next = S_SORT_WB;
        end
      end
      S_SORT_WB: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WA_I;
        cmd.wd_sel = WD_CUR;
        if (stat.i_more) begin
          cmd.i_inc  = 1'b1;
          state_next = S_SORT_LD;
        end else begin
          state_next = S_RESP;
        end
      end
      S_READ_CAP: begin
        cmd.rd_capture = 1'b1;
        state_next     = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> design/usage_ordered_record_table_top.sv
// top level of the usage ordered record table: controller plus datapath
// depends on uort_pkg, uort_ctrl, uort_dp
//
// channel   dir  handshake           payload (lsb first)
// s_*       in   s_tvalid/s_tready   req_type[3], entry_index[4], record_word[32],
//                                    new_usage[32], pad
// m_*       out  m_tvalid/m_tready   status[2], entry_count[5], read_record[32],
//                                    read_usage[32], pad
//
// one request at a time; remove shifts every later entry down one place, and
// bump runs an exchange sort over the table that walks every pair through
// the single read port of the entry memory
// a waiting response does not block the next request from being accepted
// rst clears the entry count and the state machine; memory is not cleared
module usage_ordered_record_table_top #(
  parameter int MAX_ENTRIES  = uort_pkg::MAX_ENTRIES_DEF,
  parameter int RECORD_WIDTH = uort_pkg::RECORD_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // req_type, entry_index, record_word, new_usage
  input  logic [uort_pkg::TDATA_W-1:0] s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // status, entry_count, read_record, read_usage
  output logic [uort_pkg::TDATA_W-1:0] m_tdata
);
  import uort_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  uort_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  uort_dp #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .RECORD_WIDTH (RECORD_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata)
  );

  // count never grows past a full table
  a_no_inc_when_full: assert property (@(posedge clk) disable iff (rst)
    stat.full |-> (cmd.count_op != CNT_INC))
    else $error("entry count incremented on a full table");

  // a response is only loaded into a free output register
  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("response overwrote a pending transaction");

  // one request in flight: no new accept right after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second request accepted while one is in flight");

  // the memory is never written while waiting for a request
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !cmd.wr_en)
    else $error("entry memory written while idle");

endmodule

>>> tb/sv/tb_usage_ordered_record_table_top.sv
// self-checking testbench for usage_ordered_record_table_top: directed table, then random traffic
// depends on uort_pkg and the usage_ordered_record_table_top rtl
module tb_usage_ordered_record_table_top;
  timeunit 1ns;
  timeprecision 1ps;
  import uort_pkg::*;

  localparam int DEPTH      = MAX_ENTRIES_DEF;
  localparam int N_RANDOM   = 1250;
  localparam int WDOG_LIMIT = 3000;
  localparam int DRAIN_CYC  = 400;
  localparam logic [REQ_W-1:0] REQ_SPARE6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE7 = 3'd7;

  typedef struct packed {
    logic [REQ_W-1:0]   req;
    logic [IDX_W-1:0]   idx;
    logic [WORD_W-1:0]  word;
    logic [USAGE_W-1:0] usage;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic [WORD_W-1:0]   rec;
    logic [USAGE_W-1:0]  usage;
  } resp_t;

  typedef struct packed {
    request_t rq;
    logic     typed;
    resp_t    want;
  } step_t;

  typedef enum int {MIX_GROW, MIX_CHURN, MIX_SHRINK} mix_e;

  localparam int N_DIRECTED = 25;

  // rows with typed = 1 carry a hand-written response, the rest use the predictor
  step_t plan [N_DIRECTED] = '{
    '{'{REQ_READ,   4'd0,  32'h0,        32'h0},        1'b1, '{ST_BAD_INDEX, 5'd0, 32'h0, 32'h0}},
    '{'{REQ_EDIT,   4'd0,  32'hdeadbeef, 32'd7},        1'b1, '{ST_BAD_INDEX, 5'd0, 32'h0, 32'h0}},
    '{'{REQ_REMOVE, 4'd0,  32'h0,        32'h0},        1'b1, '{ST_BAD_INDEX, 5'd0, 32'h0, 32'h0}},
    '{'{REQ_BUMP,   4'd15, 32'h0,        32'h0},        1'b1, '{ST_BAD_INDEX, 5'd0, 32'h0, 32'h0}},
    '{'{REQ_SPARE6, 4'd15, 32'hffffffff, 32'hffffffff}, 1'b1, '{ST_OK, 5'd0, 32'h0, 32'h0}},
    '{'{REQ_SPARE7, 4'd0,  32'h0,        32'h0},        1'b1, '{ST_OK, 5'd0, 32'h0, 32'h0}},
    '{'{REQ_ADD,    4'd15, 32'hffffffff, 32'hffffffff}, 1'b1, '{ST_OK, 5'd1, 32'h0, 32'h0}},
    '{'{REQ_READ,   4'd0,  32'h0,        32'h0},        1'b1, '{ST_OK, 5'd1, 32'hffffffff, 32'h0}},
    '{'{REQ_EDIT,   4'd0,  32'h0,        32'hffffffff}, 1'b1, '{ST_OK, 5'd1, 32'h0, 32'h0}},
    // usage wraps from all ones to zero
    '{'{REQ_BUMP,   4'd0,  32'h0,        32'h0},        1'b1, '{ST_OK, 5'd1, 32'h0, 32'h0}},
    '{'{REQ_READ,   4'd0,  32'h0,        32'h0},        1'b1, '{ST_OK, 5'd1, 32'h0, 32'h0}},
    '{'{REQ_ADD,    4'd0,  32'ha5a5a5a5, 32'h0},        1'b1, '{ST_OK, 5'd2, 32'h0, 32'h0}},
    '{'{REQ_ADD,    4'd0,  32'h5a5a5a5a, 32'h0},        1'b1, '{ST_OK, 5'd3, 32'h0, 32'h0}},
    '{'{REQ_EDIT,   4'd2,  32'h5a5a5a5a, 32'd5},        1'b1, '{ST_OK, 5'd3, 32'h0, 32'h0}},
    '{'{REQ_EDIT,   4'd1,  32'ha5a5a5a5, 32'd5},        1'b0, '0},
    '{'{REQ_BUMP,   4'd1,  32'h0,        32'h0},        1'b0, '0},
    '{'{REQ_READ,   4'd0,  32'h0,        32'h0},        1'b0, '0},
    '{'{REQ_READ,   4'd1,  32'h0,        32'h0},        1'b0, '0},
    '{'{REQ_READ,   4'd2,  32'h0,        32'h0},        1'b0, '0},
    '{'{REQ_READ,   4'd3,  32'h0,        32'h0},        1'b1, '{ST_BAD_INDEX, 5'd3, 32'h0, 32'h0}},
    '{'{REQ_REMOVE, 4'd0,  32'h0,        32'h0},        1'b0, '0},
    '{'{REQ_REMOVE, 4'd1,  32'h0,        32'h0},        1'b0, '0},
    '{'{REQ_CLEAR,  4'd9,  32'h0,        32'h0},        1'b1, '{ST_OK, 5'd0, 32'h0, 32'h0}},
    '{'{REQ_READ,   4'd0,  32'h0,        32'h0},        1'b1, '{ST_BAD_INDEX, 5'd0, 32'h0, 32'h0}},
    '{'{REQ_ADD,    4'd0,  32'h0,        32'h0},        1'b1, '{ST_OK, 5'd1, 32'h0, 32'h0}}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [TDATA_W-1:0]  s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [TDATA_W-1:0]  m_tdata;

  usage_ordered_record_table_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [WORD_W-1:0]  rec_mem [DEPTH];
  logic [USAGE_W-1:0] use_mem [DEPTH];
  int                 live_cnt = 0;

  resp_t resp_due [$];
  int    fail_cnt = 0;
  int    mism_cnt = 0;
  int    resp_cnt = 0;
  int    op_cnt [8] = '{default: 0};
  int    full_cnt = 0;
  int    bad_cnt = 0;
  int    deepest = 0;
  bit    no_idle = 1'b0;

  task automatic swap_entries(input int a, input int b);
    logic [WORD_W-1:0]  w;
    logic [USAGE_W-1:0] u;
    w = rec_mem[a];
    u = use_mem[a];
    rec_mem[a] = rec_mem[b];
    use_mem[a] = use_mem[b];
    rec_mem[b] = w;
    use_mem[b] = u;
  endtask

  // updates the shadow table and returns the response the block owes
  task automatic table_apply(input request_t rq, output resp_t r);
    bit ok_idx;
    ok_idx = int'(rq.idx) < live_cnt;
    r = '0;
    r.status = ST_OK;
    op_cnt[rq.req]++;
    case (rq.req)
      REQ_ADD: begin
        if (live_cnt >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          rec_mem[live_cnt] = rq.word;
          use_mem[live_cnt] = '0;
          live_cnt++;
        end
      end
      REQ_EDIT, REQ_REMOVE, REQ_BUMP, REQ_READ: begin
        if (!ok_idx) begin
          r.status = ST_BAD_INDEX;
        end else if (rq.req == REQ_EDIT) begin
          rec_mem[rq.idx] = rq.word;
          use_mem[rq.idx] = rq.usage;
        end else if (rq.req == REQ_REMOVE) begin
          for (int i = int'(rq.idx); i + 1 < live_cnt; i++) begin
            rec_mem[i] = rec_mem[i+1];
            use_mem[i] = use_mem[i+1];
          end
          live_cnt--;
        end else if (rq.req == REQ_BUMP) begin
          use_mem[rq.idx] = use_mem[rq.idx] + 1'b1;
          // exchange sort, descending, swaps only on strictly greater
          for (int i = 0; i + 1 < live_cnt; i++)
            for (int j = i + 1; j < live_cnt; j++)
              if (use_mem[j] > use_mem[i]) swap_entries(i, j);
        end else begin
          r.rec   = rec_mem[rq.idx];
          r.usage = use_mem[rq.idx];
        end
      end
      REQ_CLEAR: begin
        live_cnt = 0;
        for (int i = 0; i < DEPTH; i++) begin
          rec_mem[i] = '0;
          use_mem[i] = '0;
        end
      end
      default: ;
    endcase
    r.count = COUNT_W'(live_cnt);
    if (r.status == ST_FULL) full_cnt++;
    if (r.status == ST_BAD_INDEX) bad_cnt++;
    if (live_cnt > deepest) deepest = live_cnt;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_request(input request_t rq, input logic typed, input resp_t typed_resp);
    int    gap;
    resp_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, rq.usage, rq.word, rq.idx, rq.req};
    do @(posedge clk); while (s_tready !== 1'b1);
    table_apply(rq, pred);
    resp_due.push_back(typed ? typed_resp : pred);
  endtask

  // mostly valid positions, some at or past the entry count
  function automatic logic [IDX_W-1:0] pick_index();
    if (live_cnt < DEPTH && (live_cnt == 0 || $urandom_range(0, 99) < 8))
      return IDX_W'($urandom_range(live_cnt, DEPTH - 1));
    return IDX_W'($urandom_range(0, live_cnt - 1));
  endfunction

  function automatic logic [USAGE_W-1:0] pick_usage();
    int r;
    r = $urandom_range(0, 3);
    if (r < 2) return USAGE_W'($urandom_range(0, 20));
    if (r == 2) return $urandom;
    return 32'hffffffff - USAGE_W'($urandom_range(0, 15));
  endfunction

  function automatic request_t pick_request(input mix_e mix);
    request_t rq;
    int       r;
    rq.word  = $urandom;
    rq.usage = $urandom;
    rq.idx   = pick_index();
    r = $urandom_range(0, 999);
    if (r < 14) begin
      rq.req = REQ_CLEAR;
      return rq;
    end
    if (r < 24) begin
      rq.req = r[0] ? REQ_SPARE7 : REQ_SPARE6;
      return rq;
    end
    r = $urandom_range(0, 99);
    case (mix)
      MIX_GROW:   rq.req = r < 70 ? REQ_ADD : r < 85 ? REQ_BUMP : r < 93 ? REQ_READ : REQ_EDIT;
      MIX_SHRINK: rq.req = r < 60 ? REQ_REMOVE : r < 80 ? REQ_READ : REQ_BUMP;
      default:    rq.req = r < 40 ? REQ_BUMP : r < 65 ? REQ_READ : r < 80 ? REQ_EDIT :
                           r < 90 ? REQ_ADD : REQ_REMOVE;
    endcase
    if (rq.req == REQ_EDIT) rq.usage = pick_usage();
    return rq;
  endfunction

  // receiver stalls, held for random stretches
  int hold_left = 0;
  always @(posedge clk) begin
    if (no_idle) begin
      m_tready  <= 1'b1;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if ($urandom_range(0, 99) < 70) begin
      m_tready  <= 1'b1;
      hold_left <= $urandom_range(0, 20);
    end else begin
      m_tready  <= 1'b0;
      hold_left <= $urandom_range(0, 9) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 3);
    end
  end

  task automatic note_mismatch(input string what, input resp_t want, input resp_t got);
    mism_cnt++;
    fail_cnt++;
    if (mism_cnt <= 10)
      $display("%0t %s: exp st=%0d cnt=%0d rec=%h use=%h  got st=%0d cnt=%0d rec=%h use=%h",
               $realtime, what, want.status, want.count, want.rec, want.usage,
               got.status, got.count, got.rec, got.usage);
  endtask

  resp_t got_resp, want_resp;
  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      got_resp = '{m_tdata[1:0], m_tdata[6:2], m_tdata[38:7], m_tdata[70:39]};
      resp_cnt++;
      if (resp_due.size() == 0) begin
        note_mismatch("unexpected transaction", '0, got_resp);
      end else begin
        want_resp = resp_due.pop_front();
        if (got_resp !== want_resp) note_mismatch("response mismatch", want_resp, got_resp);
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles, %0d responses pending",
               idle_cycles, resp_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    mix_e mix;
    int   burst_left;
    mix = MIX_GROW;
    burst_left = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[k]) push_request(plan[k].rq, plan[k].typed, plan[k].want);

    for (int k = 0; k < N_RANDOM; k++) begin
      if (burst_left == 0) begin
        int r;
        r = $urandom_range(0, 99);
        mix = r < 30 ? MIX_GROW : r < 85 ? MIX_CHURN : MIX_SHRINK;
        burst_left = $urandom_range(10, 40);
      end
      burst_left--;
      // periodic stretch with no idling on either side
      if (k % 200 == 120) no_idle = 1'b1;
      if (k % 200 == 180) no_idle = 1'b0;
      push_request(pick_request(mix), 1'b0, '0);
    end
    s_tvalid <= 1'b0;
    no_idle = 1'b0;

    wait (resp_due.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("sent %0d requests: add %0d edit %0d remove %0d bump %0d clear %0d read %0d unused %0d",
             N_DIRECTED + N_RANDOM, op_cnt[REQ_ADD], op_cnt[REQ_EDIT], op_cnt[REQ_REMOVE],
             op_cnt[REQ_BUMP], op_cnt[REQ_CLEAR], op_cnt[REQ_READ],
             op_cnt[REQ_SPARE6] + op_cnt[REQ_SPARE7]);
    $display("%0d responses checked, %0d table full, %0d bad index, deepest table %0d, %0d mismatches",
             resp_cnt, full_cnt, bad_cnt, deepest, mism_cnt);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
design/uort_pkg.sv
design/uort_dp.sv
design/uort_ctrl.sv
design/usage_ordered_record_table_top.sv
tb/sv/tb_usage_ordered_record_table_top.sv
